>>> design/dtr_pkg.sv
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types and constants of the diagnostic trace recorder: record and
// command layouts, result kinds, register indexes and back-end states.
// ----------------------------------------------------------------------------
package dtr_pkg;

	localparam int unsigned MaxResults = 16;
	localparam int unsigned LimitW     = 5;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned CfgDataW   = 32;
	localparam int unsigned KindW      = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ZERO_MASK    = 2'd0,
		REG_PARTIAL_MASK = 2'd1
	} reg_idx_t;

	typedef enum logic [KindW-1:0] {
		KIND_STORED    = 3'd0,
		KIND_DROPPED   = 3'd1,
		KIND_READ      = 3'd2,
		KIND_LAST_READ = 3'd3,
		KIND_EMPTY     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [63:0] seq;
		logic [63:0] host_time;
		logic [31:0] captured;
		logic [31:0] requested;
		logic [31:0] peak;
		logic [31:0] flags;
		logic [31:0] zero_run;
		logic [31:0] partial_run;
		logic [31:0] path;
		logic [31:0] outcome;
		logic [31:0] status;
	} rec_t;

	typedef struct packed {
		logic              is_read;
		logic [LimitW-1:0] limit;
		rec_t              rec;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_READ = 1'b1
	} bk_state_t;

endpackage

>>> design/dtr_front.sv
// ----------------------------------------------------------------------------
// dtr_front
// Takes items, keeps the mask registers, the sequence counter and the two
// run counters, and builds the command pushed into the queue.
// ----------------------------------------------------------------------------
module dtr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [dtr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dtr_pkg::CfgDataW-1:0] cfg_data,
	input  logic                       accept,
	input  logic                       command,
	input  logic [63:0]                host_time,
	input  logic [31:0]                captured_frames,
	input  logic [31:0]                requested_frames,
	input  logic [31:0]                peak_bits,
	input  logic [31:0]                event_flags,
	input  logic [31:0]                path_code,
	input  logic [31:0]                outcome_code,
	input  logic signed [31:0]         status_value,
	input  logic [dtr_pkg::LimitW-1:0] read_limit,
	output dtr_pkg::cmd_t              cmd
);
	import dtr_pkg::*;

	logic [31:0] zero_mask_q;
	logic [31:0] partial_mask_q;
	logic [63:0] seq_q;
	logic [31:0] zero_run_q;
	logic [31:0] partial_run_q;

	logic [63:0] seq_next;
	logic [31:0] zero_run_next;
	logic [31:0] partial_run_next;
	logic        is_record;

	assign is_record = accept && !command;

	always_comb begin
		seq_next = (seq_q == '1) ? seq_q : seq_q + 64'd1;
		if ((event_flags & zero_mask_q) != '0) begin
			zero_run_next = (zero_run_q == '1) ? zero_run_q : zero_run_q + 32'd1;
		end else begin
			zero_run_next = '0;
		end
		if ((event_flags & partial_mask_q) != '0) begin
			partial_run_next = (partial_run_q == '1) ? partial_run_q : partial_run_q + 32'd1;
		end else begin
			partial_run_next = '0;
		end
	end

	always_comb begin
		cmd.is_read             = command;
		cmd.limit               = read_limit;
		cmd.rec.seq             = seq_next;
		cmd.rec.host_time       = host_time;
		cmd.rec.captured        = captured_frames;
		cmd.rec.requested       = requested_frames;
		cmd.rec.peak            = peak_bits;
		cmd.rec.flags           = event_flags;
		cmd.rec.zero_run        = zero_run_next;
		cmd.rec.partial_run     = partial_run_next;
		cmd.rec.path            = path_code;
		cmd.rec.outcome         = outcome_code;
		cmd.rec.status          = $unsigned(status_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_mask_q    <= 32'd1;
			partial_mask_q <= 32'd2;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ZERO_MASK:    zero_mask_q    <= cfg_data;
				REG_PARTIAL_MASK: partial_mask_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// counters advance on every record item, dropped or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q         <= '0;
			zero_run_q    <= '0;
			partial_run_q <= '0;
		end else if (is_record) begin
			seq_q         <= seq_next;
			zero_run_q    <= zero_run_next;
			partial_run_q <= partial_run_next;
		end
	end

endmodule

>>> design/dtr_cmd_queue.sv
// ----------------------------------------------------------------------------
// dtr_cmd_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module dtr_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtr_pkg::cmd_t  push_cmd,
	output logic           space,
	input  logic           pop,
	output dtr_pkg::head_t head
);
	import dtr_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign space      = (count_q != 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/dtr_back.sv
// ----------------------------------------------------------------------------
// dtr_back
// Carries out queued commands: stores or drops records in the trace memory,
// streams read records out of it and drives the output register.
// ----------------------------------------------------------------------------
module dtr_back #(
	parameter int unsigned FIFO_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dtr_pkg::head_t             head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dtr_pkg::KindW-1:0]  kind,
	output dtr_pkg::rec_t              out_rec
);
	import dtr_pkg::*;

	localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;

	rec_t            mem [FIFO_DEPTH];
	rec_t            rd_data_s1;
	logic            s1_valid_q;
	logic            s1_last_q;
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic [LimitW-1:0] remain_q;
	bk_state_t       state_q;
	bk_state_t       state_next;
	logic            out_valid_q;
	kind_t           kind_q;
	rec_t            out_rec_q;

	logic              out_free;
	logic              s1_move;
	logic              has_room;
	logic [LimitW-1:0] lim;
	logic [CmpW-1:0]   count;
	logic              emit_rec;
	logic              emit_empty;
	logic              start_read;
	logic              rd_issue;
	logic              mem_we;

	assign out_free = !out_valid_q || out_ready;
	assign s1_move  = s1_valid_q && out_free;
	assign has_room = (fill_q < CntW'(FIFO_DEPTH));

	// clamp the limit, then take the smaller of limit and fill
	always_comb begin
		lim   = (head.cmd.limit > LimitW'(MaxResults)) ? LimitW'(MaxResults) : head.cmd.limit;
		count = (CmpW'(fill_q) < CmpW'(lim)) ? CmpW'(fill_q) : CmpW'(lim);
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (start_read) begin
					state_next = BK_READ;
				end
			end
			BK_READ: begin
				if (rd_issue && remain_q == LimitW'(1)) begin
					state_next = BK_IDLE;
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		emit_rec   = 1'b0;
		emit_empty = 1'b0;
		start_read = 1'b0;
		rd_issue   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					if (!head.cmd.is_read) begin
						emit_rec = out_free && !s1_valid_q;
						pop      = emit_rec;
					end else if (count == '0) begin
						emit_empty = out_free && !s1_valid_q;
						pop        = emit_empty;
					end else begin
						start_read = 1'b1;
						pop        = 1'b1;
					end
				end
			end
			BK_READ: begin
				rd_issue = !s1_valid_q || s1_move;
			end
			default: ;
		endcase
	end

	assign mem_we = emit_rec && has_room;

	// trace memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= head.cmd.rec;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fill_q     <= '0;
			remain_q   <= '0;
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (mem_we) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
				fill_q   <= fill_q + CntW'(1);
			end else if (rd_issue) begin
				fill_q   <= fill_q - CntW'(1);
			end
			if (rd_issue) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (start_read) begin
				remain_q <= LimitW'(count);
			end else if (rd_issue) begin
				remain_q <= remain_q - LimitW'(1);
			end
			if (rd_issue) begin
				s1_valid_q <= 1'b1;
				s1_last_q  <= (remain_q == LimitW'(1));
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move || emit_rec || emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			kind_q    <= s1_last_q ? KIND_LAST_READ : KIND_READ;
			out_rec_q <= rd_data_s1;
		end else if (emit_rec) begin
			kind_q    <= has_room ? KIND_STORED : KIND_DROPPED;
			out_rec_q <= head.cmd.rec;
		end else if (emit_empty) begin
			kind_q    <= KIND_EMPTY;
			out_rec_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_rec   = out_rec_q;

endmodule

>>> design/diagnostic_trace_recorder_core.sv
// ----------------------------------------------------------------------------
// diagnostic_trace_recorder_core
// Trace recorder: a FIFO of event records with a saturating sequence number
// and two saturating run counters, echoing each record and reading back
// the oldest records on request.
//
//   channel  signals                          direction
//   in       in_valid / in_ready, item fields  into the block
//   out      out_valid / out_ready, result     out of the block
//   cfg      cfg_write, cfg_index, cfg_data    into the block, no wait
//
// A record item gives one result via the command queue and output register;
// the front takes a new item every cycle while the two-entry queue has room.
// While out_ready is high, a read item gives one record per cycle from the
// trace memory, paced by its registered read port; one result if empty.
// Stalls on out_ready back up through the output register and the queue to
// in_ready. Reset clears the counters and pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module diagnostic_trace_recorder_core #(
	parameter int unsigned FIFO_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [dtr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dtr_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [63:0]                  host_time,
	input  logic [31:0]                  captured_frames,
	input  logic [31:0]                  requested_frames,
	input  logic [31:0]                  peak_bits,
	input  logic [31:0]                  event_flags,
	input  logic [31:0]                  path_code,
	input  logic [31:0]                  outcome_code,
	input  logic signed [31:0]           status_value,
	input  logic [dtr_pkg::LimitW-1:0]   read_limit,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dtr_pkg::KindW-1:0]    kind,
	output logic [63:0]                  sequence_number,
	output logic [63:0]                  time_out,
	output logic [31:0]                  captured_out,
	output logic [31:0]                  requested_out,
	output logic [31:0]                  peak_out,
	output logic [31:0]                  flags_out,
	output logic [31:0]                  zero_run,
	output logic [31:0]                  partial_run,
	output logic [31:0]                  path_out,
	output logic [31:0]                  outcome_out,
	output logic signed [31:0]           status_out
);
	import dtr_pkg::*;

	cmd_t  front_cmd;
	head_t q_head;
	logic  q_space;
	logic  q_pop;
	logic  accept;
	rec_t  res_rec;

	assign in_ready = q_space;
	assign accept   = in_valid && q_space;

	dtr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.accept           (accept),
		.command          (command),
		.host_time        (host_time),
		.captured_frames  (captured_frames),
		.requested_frames (requested_frames),
		.peak_bits        (peak_bits),
		.event_flags      (event_flags),
		.path_code        (path_code),
		.outcome_code     (outcome_code),
		.status_value     (status_value),
		.read_limit       (read_limit),
		.cmd              (front_cmd)
	);

	dtr_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.space    (q_space),
		.pop      (q_pop),
		.head     (q_head)
	);

	dtr_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.out_rec   (res_rec)
	);

	assign sequence_number = res_rec.seq;
	assign time_out        = res_rec.host_time;
	assign captured_out    = res_rec.captured;
	assign requested_out   = res_rec.requested;
	assign peak_out        = res_rec.peak;
	assign flags_out       = res_rec.flags;
	assign zero_run        = res_rec.zero_run;
	assign partial_run     = res_rec.partial_run;
	assign path_out        = res_rec.path;
	assign outcome_out     = res_rec.outcome;
	assign status_out      = $signed(res_rec.status);

endmodule
